// ----- rtl/mms_pkg.sv -----
// Shared constants, codes and types for the streaming matrix multiply block.
`timescale 1ns / 1ps
`default_nettype none
package mms_pkg;

   localparam int MAX_DIM_DEF    = 16;
   localparam int DATA_WIDTH_DEF = 16;
   localparam int ACC_W          = 36;
   localparam int ROW_W          = 16;
   localparam int COL_W          = 4;
   localparam int DIM_CFG_W      = 5;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2
   } csr_reg_type;

   typedef enum logic {
      OP_LOAD_B   = 1'b0,
      OP_STREAM_A = 1'b1
   } opcode_type;

   typedef struct packed {
      logic load;     // write this cell's B column entry
      logic read;     // read B entry for the incoming A word
      logic mul;      // form product
      logic mac;      // accumulate product
      logic row_end;  // product closes a row: hand sum to shift chain
      logic shift;    // shift chain moves one cell toward the output
      logic clear;    // drop accumulator
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/mms_cell.sv -----
// One column cell: B column store, multiplier, accumulator and output shift stage.
`timescale 1ns / 1ps
`default_nettype none
module mms_cell #(
   parameter int MAX_DIM    = mms_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mms_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire mms_pkg::cell_ctl_type           ctl,
   input  wire logic [$clog2(MAX_DIM)-1:0]      wr_addr,
   input  wire logic [DATA_WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(MAX_DIM)-1:0]      rd_addr,
   input  wire logic signed [DATA_WIDTH-1:0]    a_data,
   input  wire logic [mms_pkg::ACC_W-1:0]       shift_in,
   output logic      [mms_pkg::ACC_W-1:0]       shift_out
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int EW = (PW > mms_pkg::ACC_W) ? PW : mms_pkg::ACC_W;

   logic        [DATA_WIDTH-1:0]     mem_ff [MAX_DIM];
   logic signed [DATA_WIDTH-1:0]     rd_ff;
   logic signed [PW-1:0]             prod_ff;
   logic signed [EW-1:0]             prod_ext;
   logic        [mms_pkg::ACC_W-1:0] acc_ff;
   logic        [mms_pkg::ACC_W-1:0] acc_in;
   logic        [mms_pkg::ACC_W-1:0] sum;
   logic        [mms_pkg::ACC_W-1:0] sh_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.read) begin
         rd_ff <= mem_ff[rd_addr];
      end
      if (ctl.mul) begin
         prod_ff <= a_data * rd_ff;
      end
   end

   assign prod_ext = EW'(prod_ff);
   assign sum      = acc_ff + prod_ext[mms_pkg::ACC_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.mac) begin
         acc_in = ctl.row_end ? '0 : sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mac && ctl.row_end) begin
         sh_ff <= sum;
      end else if (ctl.shift) begin
         sh_ff <= shift_in;
      end
   end

   assign shift_out = sh_ff;

endmodule
`default_nettype wire

// ----- rtl/matrix_multiply_stream.sv -----
// Top level: configuration, position counters, pipeline control and the cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Streaming C = A x B in signed fixed point. Load B (inner_dim x cols_b) row-major with
// opcode 0 (tuser low), then stream A row-major with opcode 1. Words are taken one per
// cycle; each A word feeds one multiply-accumulate cell per column of C, through a
// three-stage path (B read, multiply, accumulate). The word that closes an A row makes its
// row of C appear once it has passed those stages; it drains one word per cycle while the
// receiver is ready, cols_b words, column 0 first. From the closing word until that row has
// fully left the shift chain no word is taken, so result stalls hold the input off as well.
// tlast marks the last column of a row, tuser the last word of the whole result.
// Any register write restarts the positions and clears the accumulators; B contents are kept.
module matrix_multiply_stream #(
   parameter int MAX_DIM    = mms_pkg::MAX_DIM_DEF,
   parameter int DATA_WIDTH = mms_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // value (DATA_WIDTH bits), zero pad to whole bytes
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   // opcode
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // product_value [35:0], row_index [51:36], col_index [55:52]
   output logic [55:0]                               rsp_tdata,
   // matrix_last
   output logic                                      rsp_tuser,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_we,
   input  wire logic [mms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mms_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW = $clog2(MAX_DIM);
   localparam int CW = $clog2(MAX_DIM + 1);
   localparam int RW = mms_pkg::ROW_W;
   localparam int DW = mms_pkg::DIM_CFG_W;

   logic [RW-1:0] rows_a_ff;
   logic [DW-1:0] inner_dim_ff;
   logic [DW-1:0] cols_b_ff;

   logic [RW-1:0] m_dim;
   logic [CW-1:0] k_dim;
   logic [CW-1:0] n_dim;

   logic [AW-1:0] ld_row_ff, ld_col_ff;
   logic [AW-1:0] a_col_ff;
   logic [RW-1:0] a_row_ff;

   logic                  req_fire, load_fire, a_fire, rsp_fire;
   logic                  ld_col_wrap, ld_row_wrap, a_row_end, a_last_row;

   logic                  v1_ff, end1_ff, lr1_ff;
   logic                  v2_ff, end2_ff, lr2_ff;
   logic [RW-1:0]         row1_ff, row2_ff;
   logic signed [DATA_WIDTH-1:0] a1_ff;

   logic [CW-1:0]         rem_ff;
   logic [AW-1:0]         out_col_ff;
   logic [RW-1:0]         out_row_ff;
   logic                  out_lr_ff;

   logic [mms_pkg::ACC_W-1:0] chain [MAX_DIM+1];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= RW'(1);
         inner_dim_ff <= DW'(1);
         cols_b_ff    <= DW'(1);
      end else if (csr_we) begin
         case (csr_index)
            mms_pkg::REG_ROWS_A:    rows_a_ff    <= csr_wdata[RW-1:0];
            mms_pkg::REG_INNER_DIM: inner_dim_ff <= csr_wdata[DW-1:0];
            mms_pkg::REG_COLS_B:    cols_b_ff    <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      m_dim = (rows_a_ff == '0) ? RW'(1) : rows_a_ff;
      if (inner_dim_ff == '0) begin
         k_dim = CW'(1);
      end else if (int'(inner_dim_ff) > MAX_DIM) begin
         k_dim = CW'(MAX_DIM);
      end else begin
         k_dim = CW'(inner_dim_ff);
      end
      if (cols_b_ff == '0) begin
         n_dim = CW'(1);
      end else if (int'(cols_b_ff) > MAX_DIM) begin
         n_dim = CW'(MAX_DIM);
      end else begin
         n_dim = CW'(cols_b_ff);
      end
   end

   // handshake
   assign req_tready = (rem_ff == '0) && !(v1_ff && end1_ff) && !(v2_ff && end2_ff);
   assign req_fire   = req_tvalid && req_tready;
   assign load_fire  = req_fire && (req_tuser == mms_pkg::OP_LOAD_B);
   assign a_fire     = req_fire && (req_tuser == mms_pkg::OP_STREAM_A);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign ld_col_wrap = (CW'(ld_col_ff) + CW'(1)) == n_dim;
   assign ld_row_wrap = (CW'(ld_row_ff) + CW'(1)) == k_dim;
   assign a_row_end   = (CW'(a_col_ff) + CW'(1)) == k_dim;
   assign a_last_row  = ({1'b0, a_row_ff} + (RW+1)'(1)) >= {1'b0, m_dim};

   // positions
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         ld_row_ff <= '0;
         ld_col_ff <= '0;
         a_col_ff  <= '0;
         a_row_ff  <= '0;
      end else begin
         if (load_fire) begin
            if (ld_col_wrap) begin
               ld_col_ff <= '0;
               ld_row_ff <= ld_row_wrap ? '0 : ld_row_ff + AW'(1);
            end else begin
               ld_col_ff <= ld_col_ff + AW'(1);
            end
         end
         if (a_fire) begin
            if (a_row_end) begin
               a_col_ff <= '0;
               a_row_ff <= a_last_row ? '0 : a_row_ff + RW'(1);
            end else begin
               a_col_ff <= a_col_ff + AW'(1);
            end
         end
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= a_fire;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         a1_ff   <= req_tdata[DATA_WIDTH-1:0];
         end1_ff <= a_row_end;
         lr1_ff  <= a_last_row;
         row1_ff <= a_row_ff;
      end
      end2_ff <= end1_ff;
      lr2_ff  <= lr1_ff;
      row2_ff <= row1_ff;
   end

   // result drain
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         rem_ff <= '0;
      end else if (v2_ff && end2_ff) begin
         rem_ff <= n_dim;
      end else if (rsp_fire) begin
         rem_ff <= rem_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && end2_ff) begin
         out_col_ff <= '0;
         out_row_ff <= row2_ff;
         out_lr_ff  <= lr2_ff;
      end else if (rsp_fire) begin
         out_col_ff <= out_col_ff + AW'(1);
      end
   end

   // cell chain
   assign chain[MAX_DIM] = '0;

   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      mms_pkg::cell_ctl_type ctl;

      always_comb begin
         ctl.load    = load_fire && (ld_col_ff == AW'(j));
         ctl.read    = a_fire;
         ctl.mul     = v1_ff;
         ctl.mac     = v2_ff;
         ctl.row_end = end2_ff;
         ctl.shift   = rsp_fire;
         ctl.clear   = csr_we;
      end

      mms_cell #(
         .MAX_DIM    (MAX_DIM),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .wr_addr   (ld_row_ff),
         .wr_data   (req_tdata[DATA_WIDTH-1:0]),
         .rd_addr   (a_col_ff),
         .a_data    (a1_ff),
         .shift_in  (chain[j+1]),
         .shift_out (chain[j])
      );
   end

   assign rsp_tvalid = (rem_ff != '0);
   assign rsp_tlast  = (rem_ff == CW'(1));
   assign rsp_tuser  = rsp_tlast && out_lr_ff;
   assign rsp_tdata  = {mms_pkg::COL_W'(out_col_ff), out_row_ff, chain[0]};

endmodule
`default_nettype wire

// ----- rtl/mms_checker.sv -----
// Port-level checker for the streaming matrix multiply block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        csr_we
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !csr_we |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_matrix_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("matrix end without row end");

   a_row_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast && !csr_we |=> rsp_tvalid)
      else $error("result row cut short");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast && !csr_we |=>
         rsp_tdata[55:52] == $past(rsp_tdata[55:52]) + 4'd1)
      else $error("column index did not advance");

   a_row_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tdata[55:52] == 4'd0)
      else $error("new row did not start at column zero");

endmodule

bind matrix_multiply_stream mms_checker u_mms_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_we     (csr_we)
);
`default_nettype wire

// ----- verif/matrix_multiply_stream_test.sv -----
// Testbench for matrix_multiply_stream: directed and random words against a C = A x B model.
`timescale 1ns / 1ps
module matrix_multiply_stream_test;

   localparam int MAX_DIM      = mms_pkg::MAX_DIM_DEF;
   localparam int DRAIN_CYCLES = 10;
   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 200;

   typedef struct packed {
      logic [mms_pkg::ACC_W-1:0] value;
      logic [mms_pkg::ROW_W-1:0] row;
      logic [mms_pkg::COL_W-1:0] col;
      logic             row_last;
      logic             matrix_last;
   } c_elem_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic [15:0]           req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [55:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [mms_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mms_pkg::CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic signed [15:0] b_mem [MAX_DIM*MAX_DIM];
   logic [mms_pkg::ACC_W-1:0] row_sum [MAX_DIM];
   int                 b_pos;
   int                 a_col;
   int                 a_row;
   logic [15:0]        rows_reg;
   logic [4:0]         inner_reg;
   logic [4:0]         cols_reg;
   c_elem_type         c_elems_due [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int errors = 0;
   int words_sent = 0;
   int results_checked = 0;
   int cfg_writes = 0;
   int quiet_cycles = 0;

   matrix_multiply_stream #(
      .MAX_DIM    (MAX_DIM),
      .DATA_WIDTH (mms_pkg::DATA_WIDTH_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int clamp_dim(logic [4:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   function automatic void restart_run();
      int j;
      for (j = 0; j < MAX_DIM; j++) row_sum[j] = '0;
      b_pos = 0;
      a_col = 0;
      a_row = 0;
   endfunction

   function automatic void write_dim_reg(mms_pkg::csr_reg_type idx, logic [15:0] data);
      case (idx)
         mms_pkg::REG_ROWS_A: rows_reg = data;
         mms_pkg::REG_INNER_DIM: inner_reg = data[4:0];
         mms_pkg::REG_COLS_B: cols_reg = data[4:0];
         default: return;
      endcase
      restart_run();
   endfunction

   function automatic void predict_c_row(mms_pkg::opcode_type op, logic signed [15:0] val);
      int k, n, m, col, j;
      logic signed [mms_pkg::ACC_W-1:0] prod;
      c_elem_type e;
      k = clamp_dim(inner_reg);
      n = clamp_dim(cols_reg);
      m = (rows_reg == 0) ? 1 : int'(rows_reg);
      if (op == mms_pkg::OP_LOAD_B) begin
         if (b_pos >= k*n) b_pos = 0;
         b_mem[b_pos] = val;
         b_pos++;
         if (b_pos >= k*n) b_pos = 0;
         return;
      end
      col = (a_col >= k) ? 0 : a_col;
      for (j = 0; j < n; j++) begin
         prod = val * b_mem[col*n + j];
         row_sum[j] = row_sum[j] + prod;
      end
      col++;
      if (col < k) begin
         a_col = col;
         return;
      end
      for (j = 0; j < n; j++) begin
         e.value = row_sum[j];
         e.row = mms_pkg::ROW_W'(a_row);
         e.col = mms_pkg::COL_W'(j);
         e.row_last = (j == n-1);
         e.matrix_last = (j == n-1) && (a_row + 1 >= m);
         c_elems_due.push_back(e);
      end
      for (j = 0; j < MAX_DIM; j++) row_sum[j] = '0;
      a_col = 0;
      a_row = (a_row + 1 >= m) ? 0 : a_row + 1;
   endfunction

   function automatic logic [15:0] rand_q88();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic set_idling(int idle, int stall);
      idle_pct = idle;
      stall_pct = stall;
   endtask

   task automatic send_word(mms_pkg::opcode_type op, logic [15:0] val);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tuser = op;
      req_tdata = val;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_c_row(op, val);
      words_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (c_elems_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(mms_pkg::csr_reg_type idx, logic [15:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      write_dim_reg(idx, data);
      cfg_writes++;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_dims(logic [15:0] rows, logic [15:0] inner, logic [15:0] cols);
      drain();
      write_csr(mms_pkg::REG_ROWS_A, rows);
      write_csr(mms_pkg::REG_INNER_DIM, inner);
      write_csr(mms_pkg::REG_COLS_B, cols);
   endtask

   // full B load, then A rows with occasional B reloads in between
   task automatic run_random_matrix(logic [15:0] rows, logic [15:0] inner, logic [15:0] cols,
                                    int n_rows, bit all_min);
      int k, n, i;
      set_dims(rows, inner, cols);
      k = clamp_dim(inner_reg);
      n = clamp_dim(cols_reg);
      for (i = 0; i < k*n; i++)
         send_word(mms_pkg::OP_LOAD_B, all_min ? 16'h8000 : rand_q88());
      for (i = 0; i < n_rows*k; i++) begin
         if (!all_min && $urandom_range(0, 9) == 0) send_word(mms_pkg::OP_LOAD_B, rand_q88());
         send_word(mms_pkg::OP_STREAM_A, all_min ? 16'h8000 : rand_q88());
      end
   endtask

   // power-on dims are 1 x 1 x 1; second A word starts a new matrix
   task automatic test_reset_dims();
      set_idling(0, 0);
      send_word(mms_pkg::OP_LOAD_B, 16'h0180);
      send_word(mms_pkg::OP_STREAM_A, 16'hFE80);
      send_word(mms_pkg::OP_STREAM_A, 16'h7FFF);
   endtask

   task automatic test_extreme_values();
      set_dims(2, 2, 2);
      send_word(mms_pkg::OP_LOAD_B, 16'h8000);
      send_word(mms_pkg::OP_LOAD_B, 16'h7FFF);
      send_word(mms_pkg::OP_LOAD_B, 16'hFFFF);
      send_word(mms_pkg::OP_LOAD_B, 16'h0100);
      send_word(mms_pkg::OP_STREAM_A, 16'h8000);
      send_word(mms_pkg::OP_STREAM_A, 16'h8000);
      send_word(mms_pkg::OP_STREAM_A, 16'h7FFF);
      send_word(mms_pkg::OP_STREAM_A, 16'h0001);
   endtask

   // B reload wraps to B(0,0), loads between A words, row wrap, partial row left open
   task automatic test_wrap_and_interleave();
      send_word(mms_pkg::OP_LOAD_B, 16'h5555);
      send_word(mms_pkg::OP_LOAD_B, 16'hAAAA);
      send_word(mms_pkg::OP_LOAD_B, 16'h00FF);
      send_word(mms_pkg::OP_LOAD_B, 16'hFF00);
      send_word(mms_pkg::OP_LOAD_B, 16'h1234);
      send_word(mms_pkg::OP_STREAM_A, 16'h0200);
      send_word(mms_pkg::OP_LOAD_B, 16'hC000);
      send_word(mms_pkg::OP_STREAM_A, 16'hFFFE);
      send_word(mms_pkg::OP_STREAM_A, 16'h3C00);
      send_word(mms_pkg::OP_STREAM_A, 16'h8001);
      send_word(mms_pkg::OP_STREAM_A, 16'h7F00);
   endtask

   // zero dims act as 1; the write also drops the open partial row
   task automatic test_zero_dims();
      set_dims(0, 0, 0);
      send_word(mms_pkg::OP_LOAD_B, 16'hFFFF);
      send_word(mms_pkg::OP_STREAM_A, 16'h8000);
      send_word(mms_pkg::OP_STREAM_A, 16'h0001);
   endtask

   task automatic test_random_phases();
      set_idling(0, 0);
      run_random_matrix(3, 2, 3, 3, 1'b0);
      run_random_matrix(2, 31, 1, 1, 1'b1);
      set_idling(77, 0);
      run_random_matrix(65535, 2, 3, 3, 1'b0);
      set_idling(0, 77);
      run_random_matrix(4, 1, 17, 2, 1'b0);
      set_idling(12, 12);
      run_random_matrix(5, 2, 3, 3, 1'b0);
   endtask

   // receiver holds off while full-width rows keep coming, so the input stalls
   task automatic test_backpressure();
      int i;
      set_idling(0, 0);
      set_dims(4, 1, 16);
      for (i = 0; i < 16; i++) send_word(mms_pkg::OP_LOAD_B, rand_q88());
      hold_left = LONG_HOLD;
      for (i = 0; i < 6; i++) send_word(mms_pkg::OP_STREAM_A, rand_q88());
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_c_elems
      c_elem_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value = rsp_tdata[35:0];
         got.row = rsp_tdata[51:36];
         got.col = rsp_tdata[55:52];
         got.row_last = rsp_tlast;
         got.matrix_last = rsp_tuser;
         results_checked++;
         if (c_elems_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected C word: value %0d row %0d col %0d last %b/%b",
                        $signed(got.value), got.row, got.col, got.row_last, got.matrix_last);
         end else begin
            want = c_elems_due.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"C word mismatch: expected %0d (%0d,%0d) last %b/%b,",
                            " got %0d (%0d,%0d) last %b/%b"},
                           $signed(want.value), want.row, want.col, want.row_last,
                           want.matrix_last, $signed(got.value), got.row, got.col,
                           got.row_last, got.matrix_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = mms_pkg::OP_LOAD_B;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = mms_pkg::REG_ROWS_A;
      csr_wdata = '0;
      rows_reg = 16'd1;
      inner_reg = 5'd1;
      cols_reg = 5'd1;
      restart_run();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_dims();
      test_extreme_values();
      test_wrap_and_interleave();
      test_zero_dims();
      test_random_phases();
      test_backpressure();
      drain();
      if (c_elems_due.size() != 0) errors++;

      $display("Sent %0d words, checked %0d C words, made %0d register writes.",
               words_sent, results_checked, cfg_writes);
      $display("Covered reset, zero and oversize dims, Q8.8 extremes, B wrap, mixed loads, stalls.");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mms_pkg.sv
rtl/mms_cell.sv
rtl/matrix_multiply_stream.sv
rtl/mms_checker.sv
verif/matrix_multiply_stream_test.sv
